// ===== rtl/ils_pkg.sv =====
// shared types, codes and constants for the indexed list store
package ils_pkg;

  // default sizing
  localparam int ILS_CAPACITY   = 16;
  localparam int ILS_DATA_WIDTH = 32;

  // fixed field widths of the request and result beats
  localparam int FUNC_W  = 3;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  // request operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 3'd0,
    FN_READ   = 3'd1,
    FN_WRITE  = 3'd2,
    FN_REMOVE = 3'd3,
    FN_SEARCH = 3'd4,
    FN_CLEAR  = 3'd5
  } ils_func_t;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // request beat
  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } ils_in_t;

  // result beat
  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    found;
    logic [COUNT_W-1:0]      entry_count;
    logic [STAT_W-1:0]       status;
  } ils_out_t;

  // memory read address source
  typedef enum logic [2:0] {
    RD_NONE = 3'd0,
    RD_POS  = 3'd1,
    RD_IDX  = 3'd2,
    RD_DN   = 3'd3,
    RD_UP   = 3'd4
  } ils_rd_sel_t;

  // memory write source
  typedef enum logic [1:0] {
    WR_NONE    = 2'd0,
    WR_POS_VAL = 2'd1,
    WR_IDX_MEM = 2'd2
  } ils_wr_sel_t;

  // walk index update
  typedef enum logic [2:0] {
    IDX_HOLD  = 3'd0,
    IDX_COUNT = 3'd1,
    IDX_POS   = 3'd2,
    IDX_ZERO  = 3'd3,
    IDX_INC   = 3'd4,
    IDX_DEC   = 3'd5
  } ils_idx_op_t;

  // commands from controller to datapath
  typedef struct packed {
    logic        load;
    ils_rd_sel_t rd_sel;
    ils_wr_sel_t wr_sel;
    ils_idx_op_t idx_op;
    logic        cnt_inc;
    logic        cnt_dec;
    logic        cnt_clr;
    logic        cap_read;
    logic        set_found;
    logic        set_range;
    logic        set_full;
  } ils_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              cnt_zero;
    logic              pos_gt_cnt;
    logic              pos_ge_cnt;
    logic              pos_eq_cnt;
    logic              ins_last;
    logic              rm_last_now;
    logic              rm_last_next;
    logic              sr_last;
    logic              match;
  } ils_sts_t;

endpackage

// ===== rtl/indexed_list_store_core.sv =====
// top level of the indexed list store: controller plus datapath
//
// Ordered list of signed values, up to CAPACITY entries of DATA_WIDTH bits.
// A request beat (in_item: func, position, item_value) is taken at a rising
// edge with start high and busy low. Each request gives one result beat on
// out_item, marked by out_valid for exactly one cycle; the receiver has to
// take it then, as there is no back-pressure.
// Write, clear, failed requests and unused codes finish after decode;
// read adds a capture step; remove captures the value and then shifts
// later entries down; insert shifts the entries from its position up,
// then writes the new value; search compares entries in order until a
// match or the end of the list.
// busy falls the cycle after the strobe, so a new request can be taken
// from then on. Each shift or compare step takes one registered read of
// the entry memory and, for shifts, one write.
// Reset empties the list (count to zero) and returns the controller to idle;
// the entry memory is not cleared and needs no clearing pass.
module indexed_list_store_core
  import ils_pkg::*;
#(
  parameter int CAPACITY   = ILS_CAPACITY,
  parameter int DATA_WIDTH = ILS_DATA_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ils_in_t  in_item,
  output logic     out_valid,
  output ils_out_t out_item
);

  ils_cmd_t cmd;
  ils_sts_t sts;

  // sequencer
  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // storage and compare logic
  ils_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

// ===== rtl/ils_dp.sv =====
// datapath: request registers, entry memory, walk index, count and result registers
module ils_dp
  import ils_pkg::*;
#(
  parameter int CAPACITY   = ILS_CAPACITY,
  parameter int DATA_WIDTH = ILS_DATA_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ils_in_t  in_item,
  input  ils_cmd_t cmd,
  output ils_sts_t sts,
  output ils_out_t out_item
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // entry memory
  logic signed [DATA_WIDTH-1:0] mem [CAPACITY];
  logic signed [DATA_WIDTH-1:0] rdata_r;

  // request registers
  logic [FUNC_W-1:0]            func_r;
  logic [POS_W-1:0]             pos_r;
  logic signed [DATA_WIDTH-1:0] val_r;

  // control and result registers
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [VAL_W-1:0] read_value_r;
  logic                    found_r;
  logic [STAT_W-1:0]       status_r;

  logic [IDX_W-1:0]        raddr;
  logic [IDX_W-1:0]        waddr;
  logic signed [DATA_WIDTH-1:0] wdata;
  logic                    wen;
  logic [EXT_W-1:0]        idx_x, pos_x, cnt_x;

  // widened operands for the compares
  assign idx_x = EXT_W'(idx_r);
  assign pos_x = EXT_W'(pos_r);
  assign cnt_x = EXT_W'(count_r);

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_POS:  raddr = IDX_W'(pos_r);
      RD_IDX:  raddr = idx_r;
      RD_DN:   raddr = idx_r - IDX_W'(1);
      RD_UP:   raddr = idx_r + IDX_W'(1);
      default: raddr = idx_r;
    endcase
  end

  // write address and data select
  always_comb begin
    case (cmd.wr_sel)
      WR_POS_VAL: begin
        wen   = 1'b1;
        waddr = IDX_W'(pos_r);
        wdata = val_r;
      end
      WR_IDX_MEM: begin
        wen   = 1'b1;
        waddr = idx_r;
        wdata = rdata_r;
      end
      default: begin
        wen   = 1'b0;
        waddr = idx_r;
        wdata = rdata_r;
      end
    endcase
  end

  // memory write port and registered read port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_sel != RD_NONE) begin
      rdata_r <= mem[raddr];
    end
  end

  // walk index next value
  always_comb begin
    case (cmd.idx_op)
      IDX_COUNT: idx_nxt = IDX_W'(count_r);
      IDX_POS:   idx_nxt = IDX_W'(pos_r);
      IDX_ZERO:  idx_nxt = '0;
      IDX_INC:   idx_nxt = idx_r + IDX_W'(1);
      IDX_DEC:   idx_nxt = idx_r - IDX_W'(1);
      default:   idx_nxt = idx_r;
    endcase
  end

  // entry count next value
  always_comb begin
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // count is control state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // request capture, walk index and result registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      func_r       <= in_item.func;
      pos_r        <= in_item.position;
      val_r        <= DATA_WIDTH'(in_item.item_value);
      read_value_r <= '0;
      found_r      <= 1'b0;
      status_r     <= ST_OK;
    end else begin
      if (cmd.cap_read) begin
        read_value_r <= VAL_W'(rdata_r);
      end
      if (cmd.set_found) begin
        found_r <= 1'b1;
      end
      if (cmd.set_full) begin
        status_r <= ST_FULL;
      end else if (cmd.set_range) begin
        status_r <= ST_RANGE;
      end
    end
  end

  // status towards the controller
  assign sts.func         = func_r;
  assign sts.full         = (count_r == CNT_W'(CAPACITY));
  assign sts.cnt_zero     = (count_r == '0);
  assign sts.pos_gt_cnt   = (pos_x > cnt_x);
  assign sts.pos_ge_cnt   = (pos_x >= cnt_x);
  assign sts.pos_eq_cnt   = (pos_x == cnt_x);
  assign sts.ins_last     = (idx_x == pos_x + EXT_W'(1));
  assign sts.rm_last_now  = (idx_x + EXT_W'(1) == cnt_x);
  assign sts.rm_last_next = (idx_x + EXT_W'(2) == cnt_x);
  assign sts.sr_last      = (idx_x + EXT_W'(1) == cnt_x);
  assign sts.match        = (rdata_r == val_r);

  // result beat
  assign out_item.read_value  = read_value_r;
  assign out_item.found       = found_r;
  assign out_item.entry_count = COUNT_W'(count_r);
  assign out_item.status      = status_r;

  // count stays within capacity and only moves where it may
  a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");
  a_inc_not_full : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> count_r != CNT_W'(CAPACITY))
    else $error("insert into a full list");
  a_dec_not_empty : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> count_r != '0)
    else $error("remove from an empty list");
  a_inc_grows : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc && !cmd.cnt_clr |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("count did not grow on insert");

endmodule

// ===== rtl/ils_ctrl.sv =====
// controller: sequences each request over the datapath
module ils_ctrl
  import ils_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  ils_sts_t sts,
  output ils_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_DECODE  = 12'b0000_0000_0010,
    S_INS_RD  = 12'b0000_0000_0100,
    S_INS_WR  = 12'b0000_0000_1000,
    S_INS_PUT = 12'b0000_0001_0000,
    S_RD_CAP  = 12'b0000_0010_0000,
    S_RM_CAP  = 12'b0000_0100_0000,
    S_RM_RD   = 12'b0000_1000_0000,
    S_RM_WR   = 12'b0001_0000_0000,
    S_SR_RD   = 12'b0010_0000_0000,
    S_SR_CMP  = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } ils_state_t;

  ils_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (sts.func)
          FN_INSERT: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
            end else if (sts.pos_gt_cnt) begin
              cmd.set_range = 1'b1;
            end else if (sts.pos_eq_cnt) begin
              state_nxt = S_INS_PUT;
            end else begin
              cmd.idx_op = IDX_COUNT;
              state_nxt  = S_INS_RD;
            end
          end
          FN_READ: begin
            if (sts.pos_ge_cnt) begin
              cmd.set_range = 1'b1;
            end else begin
              cmd.rd_sel = RD_POS;
              state_nxt  = S_RD_CAP;
            end
          end
          FN_WRITE: begin
            if (sts.pos_ge_cnt) begin
              cmd.set_range = 1'b1;
            end else begin
              cmd.wr_sel = WR_POS_VAL;
            end
          end
          FN_REMOVE: begin
            if (sts.pos_ge_cnt) begin
              cmd.set_range = 1'b1;
            end else begin
              cmd.rd_sel = RD_POS;
              cmd.idx_op = IDX_POS;
              state_nxt  = S_RM_CAP;
            end
          end
          FN_SEARCH: begin
            if (!sts.cnt_zero) begin
              cmd.idx_op = IDX_ZERO;
              state_nxt  = S_SR_RD;
            end
          end
          FN_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      // insert: move entries up one place, top down
      S_INS_RD: begin
        cmd.rd_sel = RD_DN;
        state_nxt  = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.wr_sel = WR_IDX_MEM;
        cmd.idx_op = IDX_DEC;
        state_nxt  = sts.ins_last ? S_INS_PUT : S_INS_RD;
      end
      S_INS_PUT: begin
        cmd.wr_sel  = WR_POS_VAL;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_DONE;
      end
      S_RD_CAP: begin
        cmd.cap_read = 1'b1;
        state_nxt    = S_DONE;
      end
      // remove: take the value out, then move later entries down
      S_RM_CAP: begin
        cmd.cap_read = 1'b1;
        if (sts.rm_last_now) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_RM_RD;
        end
      end
      S_RM_RD: begin
        cmd.rd_sel = RD_UP;
        state_nxt  = S_RM_WR;
      end
      S_RM_WR: begin
        cmd.wr_sel = WR_IDX_MEM;
        cmd.idx_op = IDX_INC;
        if (sts.rm_last_next) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_RM_RD;
        end
      end
      // search: one held entry compared per pass
      S_SR_RD: begin
        cmd.rd_sel = RD_IDX;
        state_nxt  = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (sts.match) begin
          cmd.set_found = 1'b1;
          state_nxt     = S_DONE;
        end else if (sts.sr_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_op = IDX_INC;
          state_nxt  = S_SR_RD;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // handshake outputs
  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  a_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");
  a_accept_decode : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == S_DECODE)
    else $error("accepted request not decoded");
  a_single_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");
  a_no_write_idle : assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> cmd.wr_sel == WR_NONE && !cmd.cnt_inc && !cmd.cnt_dec)
    else $error("list changed while idle");

endmodule
